### sv/set_pkg.sv
package set_pkg;

  // Default frame limits.
  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned MaxHeightDef = 4096;

  // Register file layout.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_EDGE_THRESH  = 2'd2,
    CFG_FILL_DEAD    = 2'd3
  } cfg_idx_e;

  localparam logic [11:0] WidthReset  = 12'd640;
  localparam logic [12:0] HeightReset = 13'd480;
  localparam logic [8:0]  ThreshReset = 9'd128;

  // Payload widths.
  localparam int unsigned PixW = 8;
  localparam int unsigned RowW = 12;
  localparam int unsigned ColW = 11;

  // Squared gradient sum and the largest value whose root stays below 256.
  localparam int unsigned SumW = 21;
  localparam logic [SumW-1:0] SqMax = 21'd65025;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROOT,
    S_WAIT,
    S_EMIT
  } state_e;

  // The four possible results of one pixel, in raster order.
  typedef enum logic [1:0] {
    K_CENTER   = 2'd0,
    K_ROW_END  = 2'd1,
    K_LAST_ROW = 2'd2,
    K_CORNER   = 2'd3
  } res_kind_e;

  // Handshake between the sequencer and the root unit.
  typedef struct packed {
    logic        done;
    logic [7:0]  mag;
  } root_res_t;

endpackage

### sv/set_in_if.sv
interface set_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] gray_pixel;

  modport source (output valid, output gray_pixel, input ready);
  modport sink (input valid, input gray_pixel, output ready);
endinterface

### sv/set_out_if.sv
interface set_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_pixel;
  logic        is_edge;
  logic [11:0] out_row;
  logic [10:0] out_col;
  logic        last_of_run;

  modport source (output valid, output out_pixel, output is_edge, output out_row,
                  output out_col, output last_of_run, input ready);
  modport sink (input valid, input out_pixel, input is_edge, input out_row,
                input out_col, input last_of_run, output ready);
endinterface

### sv/set_ram.sv
module set_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### sv/set_root.sv
module set_root (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [15:0]         op_i,
  output set_pkg::root_res_t  res_o
);

  import set_pkg::*;

  logic        busy_q, busy_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [15:0] op_q, op_d;
  logic [9:0]  rem_q, rem_d;
  logic [7:0]  root_q, root_d;
  logic [9:0]  rem_sh;
  logic [9:0]  trial;

  // One result bit per cycle, restoring square root with a remainder.
  always_comb begin
    rem_sh = {rem_q[7:0], op_q[15:14]};
    trial  = {root_q, 2'b01};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    op_d   = op_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      op_d   = op_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      op_d  = {op_q[13:0], 2'b00};
      cnt_d = cnt_q + 3'd1;
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[6:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[6:0], 1'b0};
      end
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  // Ceiling: a nonzero remainder rounds the floor root up.
  assign res_o.done = busy_q && (cnt_q == 3'd7);
  assign res_o.mag  = root_d + {7'd0, (rem_d != 10'd0)};

endmodule

### sv/sobel_edge_threshold.sv
// Sobel edge threshold: takes 8-bit gray pixels in raster order and returns,
// for each pixel, either its clamped Sobel magnitude (flagged as an edge when it
// reaches edge_threshold) or its gray value, or zero when fill_dead_space is
// set; border pixels pass through. A pixel is reported one row and one column
// after it arrives, and the last row and column are flushed with the frame's
// final pixels, so one request yields zero to four results, the last marked.
// Both previous rows live in one line memory, read and rewritten at the
// current column. Pixels are handled one at a time: a pixel that releases no
// result passes the idle and load states; one that does also passes the root
// and emit states, emitting once per result, and an interior pixel waits on
// the bit-serial root unit (skipped when its squared sum already saturates
// the magnitude); the result side can stall each emit. The user must write
// configuration only while the block is idle; the block does not enforce it.
module sobel_edge_threshold #(
  parameter int unsigned MAX_WIDTH  = set_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = set_pkg::MaxHeightDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  set_in_if.sink                          in_if,
  set_out_if.source                       out_if,
  input  logic                            cfg_we_i,
  input  logic [set_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [set_pkg::CfgDataW-1:0]    cfg_data_i
);

  import set_pkg::*;

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);

  state_e state_q, state_d;

  logic [11:0] width_q;
  logic [12:0] height_q;
  logic [8:0]  thresh_q;
  logic        fill_q;

  logic [XW-1:0] col_q, col_d;
  logic [YW-1:0] row_q, row_d;
  logic [47:0]   win_q, win_d;

  logic [XW-1:0] wm1, c_now;
  logic [YW-1:0] hm1, r_now;

  logic [XW-1:0]   c_q;
  logic [YW-1:0]   r_q;
  logic [PixW-1:0] bot_q, mid_q, m1_q, b1_q, mag_q;
  logic [SumW-1:0] s_q;
  logic            interior_q;
  logic [3:0]      pend_q, pend_d;

  logic [15:0] ram_rdata;
  logic        ram_we;
  logic [7:0]  top, mid;
  logic [7:0]  t1, m1, b1, t2, m2, b2;
  logic [9:0]  sv_top, sv_bot, sh_lft, sh_rgt;
  logic signed [10:0] gv, gh;
  logic [19:0] gv_sq, gh_sq;
  logic [SumW-1:0] s_now;
  logic        has_a, has_b, has_c, has_d, inter_now;

  logic        root_start;
  root_res_t   root_res;

  logic        out_valid_q;
  logic        emit_load;
  res_kind_e   kind;
  logic [3:0]  pend_next;
  logic [PixW-1:0] e_pix;
  logic        e_edge;
  logic [YW-1:0] e_row;
  logic [XW-1:0] e_col;
  logic        reach;

  // Effective frame limits and the position of the next pixel.
  always_comb begin
    if (width_q < 12'd3) begin
      wm1 = XW'(2);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      wm1 = XW'(MAX_WIDTH - 1);
    end else begin
      wm1 = XW'(width_q - 12'd1);
    end
    if (height_q < 13'd3) begin
      hm1 = YW'(2);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      hm1 = YW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = YW'(height_q - 13'd1);
    end
    c_now = (col_q < wm1) ? col_q : wm1;
    r_now = (row_q < hm1) ? row_q : hm1;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      thresh_q <= ThreshReset;
      fill_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[11:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[12:0];
        CFG_EDGE_THRESH:  thresh_q <= cfg_data_i[8:0];
        CFG_FILL_DEAD:    fill_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Line memory: upper byte is the row above, lower byte two rows above.
  set_ram #(
    .Width (16),
    .Depth (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_q),
    .wdata_i ({bot_q, mid}),
    .re_i    (in_if.valid && in_if.ready),
    .raddr_i (c_now),
    .rdata_o (ram_rdata)
  );

  assign mid = ram_rdata[15:8];
  assign top = ram_rdata[7:0];
  assign t1  = win_q[7:0];
  assign m1  = win_q[15:8];
  assign b1  = win_q[23:16];
  assign t2  = win_q[31:24];
  assign m2  = win_q[39:32];
  assign b2  = win_q[47:40];

  // Gradients and their squared sum; the squares are formed at full width.
  always_comb begin
    sv_top = 10'(t2) + {1'b0, t1, 1'b0} + 10'(top);
    sv_bot = 10'(b2) + {1'b0, b1, 1'b0} + 10'(bot_q);
    sh_lft = 10'(t2) + {1'b0, m2, 1'b0} + 10'(b2);
    sh_rgt = 10'(top) + {1'b0, mid, 1'b0} + 10'(bot_q);
    gv     = $signed({1'b0, sv_top}) - $signed({1'b0, sv_bot});
    gh     = $signed({1'b0, sh_lft}) - $signed({1'b0, sh_rgt});
    gv_sq  = 20'($unsigned(21'(gv) * 21'(gv)));
    gh_sq  = 20'($unsigned(21'(gh) * 21'(gh)));
    s_now  = {1'b0, gv_sq} + {1'b0, gh_sq};
  end

  // Which results this pixel causes.
  always_comb begin
    has_a     = (r_q >= YW'(1)) && (c_q >= XW'(1));
    inter_now = (r_q >= YW'(2)) && (c_q >= XW'(2));
    has_b     = has_a && (c_q == wm1);
    has_c     = (r_q == hm1) && (c_q >= XW'(1));
    has_d     = has_c && (c_q == wm1);
  end

  set_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .op_i    (s_q[15:0]),
    .res_o   (root_res)
  );

  // Pick the next pending result.
  always_comb begin
    if (pend_q[0]) begin
      kind = K_CENTER;
    end else if (pend_q[1]) begin
      kind = K_ROW_END;
    end else if (pend_q[2]) begin
      kind = K_LAST_ROW;
    end else begin
      kind = K_CORNER;
    end
    pend_next = pend_q & ~(4'b0001 << kind);
    reach     = {1'b0, mag_q} >= thresh_q;
    e_edge    = 1'b0;
    unique case (kind)
      K_CENTER: begin
        e_row = r_q - YW'(1);
        e_col = c_q - XW'(1);
        if (interior_q && reach) begin
          e_pix  = mag_q;
          e_edge = 1'b1;
        end else if (interior_q && fill_q) begin
          e_pix = '0;
        end else begin
          e_pix = m1_q;
        end
      end
      K_ROW_END: begin
        e_row = r_q - YW'(1);
        e_col = c_q;
        e_pix = mid_q;
      end
      K_LAST_ROW: begin
        e_row = r_q;
        e_col = c_q - XW'(1);
        e_pix = b1_q;
      end
      default: begin
        e_row = r_q;
        e_col = c_q;
        e_pix = bot_q;
      end
    endcase
  end

  // Sequencer: next state and control.
  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    win_d      = win_q;
    pend_d     = pend_q;
    ram_we     = 1'b0;
    root_start = 1'b0;
    emit_load  = 1'b0;
    in_if.ready = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        ram_we = 1'b1;
        win_d  = {win_q[23:0], bot_q, mid, top};
        pend_d = {has_d, has_c, has_b, has_a};
        if (c_q == wm1) begin
          col_d = '0;
          row_d = (r_q == hm1) ? '0 : r_q + YW'(1);
        end else begin
          col_d = c_q + XW'(1);
          row_d = r_q;
        end
        state_d = (has_a || has_c) ? S_ROOT : S_IDLE;
      end
      S_ROOT: begin
        if (interior_q && (s_q <= SqMax)) begin
          root_start = 1'b1;
          state_d    = S_WAIT;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_WAIT: begin
        if (root_res.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_if.ready) begin
          emit_load = 1'b1;
          pend_d    = pend_next;
          if (pend_next == 4'd0) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      win_q       <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      win_q   <= win_d;
      pend_q  <= pend_d;
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-pixel working registers and the output register.
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      bot_q <= in_if.gray_pixel;
      c_q   <= c_now;
      r_q   <= r_now;
    end
    if (state_q == S_LOAD) begin
      mid_q      <= mid;
      m1_q       <= m1;
      b1_q       <= b1;
      s_q        <= s_now;
      interior_q <= inter_now;
    end
    if (state_q == S_ROOT) begin
      mag_q <= 8'd255;
    end else if (state_q == S_WAIT && root_res.done) begin
      mag_q <= root_res.mag;
    end
    if (emit_load) begin
      out_if.out_pixel   <= e_pix;
      out_if.is_edge     <= e_edge;
      out_if.out_row     <= RowW'(e_row);
      out_if.out_col     <= ColW'(e_col);
      out_if.last_of_run <= (pend_next == 4'd0);
    end
  end

  assign out_if.valid = out_valid_q;

endmodule

### tb/sv/sobel_edge_threshold_tb.sv
`timescale 1ns / 100ps

// Expected result of one output request.
typedef struct {
  logic [7:0]  pix;
  logic        edge_flag;
  logic [11:0] row;
  logic [10:0] col;
  logic        last;
} sobel_res_t;

// Running copy of the edge filter: line stores, window, counters and registers.
class sobel_scoreboard;
  logic [7:0]  above_line[2048];
  logic [7:0]  two_above_line[2048];
  logic [7:0]  win[6];
  int unsigned col_cnt, row_cnt;
  int unsigned width_reg, height_reg, thresh_reg, fill_reg;
  sobel_res_t  pending[$];
  int unsigned errors, results_seen, edges_seen;

  function new();
    foreach (above_line[i]) begin
      above_line[i] = '0;
      two_above_line[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    col_cnt = 0;
    row_cnt = 0;
    width_reg = 640;
    height_reg = 480;
    thresh_reg = 128;
    fill_reg = 0;
  endfunction

  function void write_reg(set_pkg::cfg_idx_e idx, int unsigned val);
    case (idx)
      set_pkg::CFG_IMAGE_WIDTH: width_reg = val & 12'hfff;
      set_pkg::CFG_IMAGE_HEIGHT: height_reg = val & 13'h1fff;
      set_pkg::CFG_EDGE_THRESH: thresh_reg = val & 9'h1ff;
      default: fill_reg = val & 1;
    endcase
  endfunction

  function void add(logic [7:0] pix, logic e, int unsigned r, int unsigned c);
    sobel_res_t x;
    x.pix = pix;
    x.edge_flag = e;
    x.row = r[11:0];
    x.col = c[10:0];
    x.last = 1'b0;
    pending = {pending, x};
  endfunction

  // Integer ceiling of the root, saturated at 255.
  function int unsigned ceil_root(int unsigned s);
    int unsigned v;
    v = 0;
    if (s > 65025) return 255;
    while (v * v < s) v++;
    return v;
  endfunction

  // Note an accepted pixel and queue the results it releases.
  function void note_pixel(logic [7:0] bot);
    int unsigned w, h, c, r, mag, s, n0;
    int gv, gh;
    logic [7:0] mid, top;
    w = (width_reg < 3) ? 3 : (width_reg > 2048 ? 2048 : width_reg);
    h = (height_reg < 3) ? 3 : (height_reg > 4096 ? 4096 : height_reg);
    c = (col_cnt < w - 1) ? col_cnt : w - 1;
    r = (row_cnt < h - 1) ? row_cnt : h - 1;
    mid = above_line[c];
    top = two_above_line[c];
    n0 = pending.size();
    if (r >= 1 && c >= 1) begin
      if (r >= 2 && c >= 2) begin
        gv = (win[3] + 2 * win[0] + top) - (win[5] + 2 * win[2] + bot);
        gh = (win[3] + 2 * win[4] + win[5]) - (top + 2 * mid + bot);
        s = gv * gv + gh * gh;
        mag = ceil_root(s);
        if (mag >= thresh_reg) add(mag[7:0], 1'b1, r - 1, c - 1);
        else add(fill_reg ? 8'd0 : win[1], 1'b0, r - 1, c - 1);
      end else begin
        add(win[1], 1'b0, r - 1, c - 1);
      end
      if (c == w - 1) add(mid, 1'b0, r - 1, c);
    end
    if (r == h - 1 && c >= 1) begin
      add(win[2], 1'b0, r, c - 1);
      if (c == w - 1) add(bot, 1'b0, r, c);
    end
    if (pending.size() > n0) pending[pending.size() - 1].last = 1'b1;
    // Shift the window one column and update the line stores.
    win[3] = win[0];
    win[4] = win[1];
    win[5] = win[2];
    win[0] = top;
    win[1] = mid;
    win[2] = bot;
    two_above_line[c] = mid;
    above_line[c] = bot;
    if (c == w - 1) begin
      col_cnt = 0;
      row_cnt = (r == h - 1) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
  endfunction

  // Compare one accepted result with the oldest expectation.
  function void check_result(sobel_res_t got);
    sobel_res_t want;
    results_seen++;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: unexpected result pix=%0d edge=%0d row=%0d col=%0d last=%0d", $time,
               got.pix, got.edge_flag, got.row, got.col, got.last);
      return;
    end
    want = pending.pop_front();
    if (want.edge_flag) edges_seen++;
    if (got.pix !== want.pix || got.edge_flag !== want.edge_flag || got.row !== want.row ||
        got.col !== want.col || got.last !== want.last) begin
      errors++;
      $display("%0t: mismatch expected pix=%0d edge=%0d row=%0d col=%0d last=%0d", $time,
               want.pix, want.edge_flag, want.row, want.col, want.last);
      $display("%0t:          actual pix=%0d edge=%0d row=%0d col=%0d last=%0d", $time,
               got.pix, got.edge_flag, got.row, got.col, got.last);
    end
  endfunction
endclass

module sobel_edge_threshold_tb;
  import set_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  set_in_if in_ch();
  set_out_if out_ch();

  sobel_scoreboard sb;
  int unsigned send_gap_max, recv_gap_max, frames_sent, pixels_sent;

  sobel_edge_threshold uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Overall time limit.
  initial begin
    #60ms;
    $display("sobel_edge_threshold test failed");
    $finish;
  end

  // Register write while the block is idle.
  task automatic write_cfg(cfg_idx_e idx, int unsigned val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val[CfgDataW-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Offer one pixel after a random gap and hold it until accepted.
  task automatic send_pixel(logic [7:0] px);
    logic taken;
    repeat ($urandom_range(0, send_gap_max)) @(negedge clk_i);
    in_ch.valid = 1'b1;
    in_ch.gray_pixel = px;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = in_ch.ready;
      if (taken) sb.note_pixel(px);
      @(negedge clk_i);
    end
    in_ch.valid = 1'b0;
    pixels_sent++;
  endtask

  // One frame with the given registers; pattern chooses the pixel content.
  task automatic run_frame(int unsigned w, int unsigned h, int unsigned thr, int unsigned fill,
                           int unsigned pattern);
    int unsigned wu, hu, r, c;
    logic [7:0] px;
    // Let any work still in flight drain before touching the registers.
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    write_cfg(CFG_IMAGE_WIDTH, w);
    write_cfg(CFG_IMAGE_HEIGHT, h);
    write_cfg(CFG_EDGE_THRESH, thr);
    write_cfg(CFG_FILL_DEAD, fill);
    wu = (w < 3) ? 3 : (w > 2048 ? 2048 : w);
    hu = (h < 3) ? 3 : (h > 4096 ? 4096 : h);
    for (r = 0; r < hu; r++) begin
      for (c = 0; c < wu; c++) begin
        case (pattern)
          0: px = 8'($urandom_range(0, 255));
          1: px = ((r + c) & 1) ? 8'd255 : 8'd0;
          2: px = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          3: px = (c > wu / 2) ? 8'd255 : 8'd0;
          default: px = 8'((r * 40 + c * 15) & 8'hff);
        endcase
        send_pixel(px);
      end
    end
    frames_sent++;
  endtask

  // Result side: random stalls, checks every accepted result.
  initial begin
    sobel_res_t got;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ch.ready = 1'b0;
      repeat ($urandom_range(0, recv_gap_max)) @(negedge clk_i);
      out_ch.ready = 1'b1;
      do begin
        @(posedge clk_i);
        if (out_ch.valid) begin
          got.pix = out_ch.out_pixel;
          got.edge_flag = out_ch.is_edge;
          got.row = out_ch.out_row;
          got.col = out_ch.out_col;
          got.last = out_ch.last_of_run;
          sb.check_result(got);
        end
      end while (!out_ch.valid);
    end
  end

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_IMAGE_WIDTH;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.gray_pixel = '0;
    send_gap_max = 17;
    recv_gap_max = 17;
    frames_sent = 0;
    pixels_sent = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed frames: checkerboards at zero and disabled thresholds, a step edge at 255.
    run_frame(3, 3, 0, 1, 1);
    run_frame(0, 0, 256, 0, 1);
    run_frame(4, 3, 255, 1, 3);

    // Random frames of small size with varied registers and idling.
    while (pixels_sent < 160) begin
      case ($urandom_range(0, 3))
        0: begin send_gap_max = 0; recv_gap_max = 0; end
        1: begin send_gap_max = 17; recv_gap_max = 0; end
        2: begin send_gap_max = 0; recv_gap_max = 17; end
        default: begin send_gap_max = 17; recv_gap_max = 17; end
      endcase
      run_frame($urandom_range(2, 8), $urandom_range(2, 6),
                ($urandom_range(0, 5) == 0) ? $urandom_range(256, 511) : $urandom_range(0, 256),
                $urandom_range(0, 1), $urandom_range(0, 4));
    end

    // A last frame with short gaps on both sides.
    send_gap_max = 2;
    recv_gap_max = 2;
    run_frame(5, 4, 128, 0, 2);

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    $display("Covered %0d frames, %0d pixels, %0d results checked (%0d edges).",
             frames_sent, pixels_sent, sb.results_seen, sb.edges_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("sobel_edge_threshold test passed");
    end else begin
      $display("sobel_edge_threshold test failed");
    end
    $finish;
  end
endmodule

### files.f
sv/set_pkg.sv
sv/set_in_if.sv
sv/set_out_if.sv
sv/set_ram.sv
sv/set_root.sv
sv/sobel_edge_threshold.sv
tb/sv/sobel_edge_threshold_tb.sv
